// File: src/assert_macros.svh
// Concurrent assertion macros for the RTL; only the datapath (lru_dp) includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("concurrent assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// File: src/lru_pkg.sv
// Shared constants and controller/datapath interface types for the LRU block.
`timescale 1ns / 1ps
package lru_pkg;

	localparam int DEF_FRAMES    = 8;
	localparam int DEF_PAGE_BITS = 16;
	localparam int CFG_BITS      = 4;
	localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;
	localparam int COUNT_BITS    = 32;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic init;    // latch the request and clear the scan trackers
		logic read;    // read frame at the scan index and advance it
		logic commit;  // apply the replacement and present the result
	} lru_cmd_t;

	typedef struct packed {
		logic last;    // scan index is at the last frame in use
	} lru_status_t;

endpackage

// File: src/lru_ctrl.sv
// Sequencer: scan of the frames in use, drain, commit.
`timescale 1ns / 1ps
module lru_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  lru_pkg::lru_status_t status,
	output lru_pkg::lru_cmd_t    cmd,
	output logic                 busy
);
	import lru_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.init = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.read = 1'b1;
				if (status.last) begin
					state_d = ST_DRAIN;
				end
			end
			// last read word is compared in this cycle
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// File: src/lru_dp.sv
// Datapath: page memory, valid/rank cells, scan trackers, counters, result registers.
`timescale 1ns / 1ps
module lru_dp #(
	parameter int FRAMES    = lru_pkg::DEF_FRAMES,
	parameter int PAGE_BITS = lru_pkg::DEF_PAGE_BITS,
	localparam int SLOT_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lru_pkg::lru_cmd_t             cmd,
	output lru_pkg::lru_status_t          status,
	input  logic                          cfg_we,
	input  logic [lru_pkg::CFG_BITS-1:0]  cfg_wdata,
	input  logic [PAGE_BITS-1:0]          page_number,
	output logic                          done,
	output logic                          hit,
	output logic [SLOT_BITS-1:0]          frame_slot,
	output logic                          evicted_valid,
	output logic [PAGE_BITS-1:0]          evicted_page,
	output logic [lru_pkg::COUNT_BITS-1:0] hit_total,
	output logic [lru_pkg::COUNT_BITS-1:0] fault_total
);
	import lru_pkg::*;
	`include "assert_macros.svh"

	localparam int CNT_BITS = $clog2(FRAMES + 1);

	logic [CFG_BITS-1:0]  cfg_q;
	logic [CNT_BITS-1:0]  n_act;

	logic [PAGE_BITS-1:0] page_q;
	logic [CNT_BITS-1:0]  idx_q;
	logic [SLOT_BITS-1:0] idx;

	logic [PAGE_BITS-1:0] mem [FRAMES];
	logic                 valid_q [FRAMES];
	logic [SLOT_BITS-1:0] rank_q [FRAMES];

	logic                 rd_v_s1;
	logic [SLOT_BITS-1:0] rd_idx_s1;
	logic [PAGE_BITS-1:0] rd_page_s1;
	logic                 rd_valid_s1;
	logic [SLOT_BITS-1:0] rd_rank_s1;

	logic                 found_q;
	logic [SLOT_BITS-1:0] found_slot_q;
	logic [SLOT_BITS-1:0] found_rank_q;
	logic [CNT_BITS-1:0]  used_q;
	logic [SLOT_BITS-1:0] worst_rank_q;
	logic [SLOT_BITS-1:0] worst_slot_q;
	logic [PAGE_BITS-1:0] worst_page_q;

	logic [SLOT_BITS-1:0] slot_d;
	logic [CNT_BITS-1:0]  orank_d;
	logic                 evict_d;
	logic [PAGE_BITS-1:0] evpage_d;

	logic [COUNT_BITS-1:0] hit_cnt_q;
	logic [COUNT_BITS-1:0] fault_cnt_q;
	logic                  done_q;
	logic                  hit_q;
	logic [SLOT_BITS-1:0]  slot_q;
	logic                  evict_q;
	logic [PAGE_BITS-1:0]  evpage_q;

	// clamp the frame count to 1..FRAMES
	always_comb begin
		if (cfg_q == '0) begin
			n_act = CNT_BITS'(1);
		end else if (int'(cfg_q) > FRAMES) begin
			n_act = CNT_BITS'(FRAMES);
		end else begin
			n_act = CNT_BITS'(cfg_q);
		end
	end

	assign idx         = idx_q[SLOT_BITS-1:0];
	assign status.last = (idx_q == n_act - CNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// page memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_page_s1 <= mem[idx];
		end
		if (cmd.commit) begin
			mem[slot_d] <= page_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			page_q <= page_number;
		end
		if (cmd.read) begin
			rd_idx_s1   <= idx;
			rd_valid_s1 <= valid_q[idx];
			rd_rank_s1  <= rank_q[idx];
		end
	end

	// scan index and match / oldest trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
			found_q <= 1'b0;
			used_q  <= '0;
		end else begin
			rd_v_s1 <= cmd.read;
			if (cmd.init) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				used_q  <= '0;
			end else begin
				if (cmd.read) begin
					idx_q <= idx_q + CNT_BITS'(1);
				end
				if (rd_v_s1 && rd_valid_s1) begin
					used_q <= used_q + CNT_BITS'(1);
					if (!found_q && rd_page_s1 == page_q) begin
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			worst_rank_q <= '0;
			worst_slot_q <= '0;
		end else if (rd_v_s1) begin
			if (rd_valid_s1 && !found_q && rd_page_s1 == page_q) begin
				found_slot_q <= rd_idx_s1;
				found_rank_q <= rd_rank_s1;
			end
			// ties go to the higher frame
			if (rd_rank_s1 >= worst_rank_q) begin
				worst_rank_q <= rd_rank_s1;
				worst_slot_q <= rd_idx_s1;
				worst_page_q <= rd_page_s1;
			end
		end
	end

	always_comb begin
		evict_d  = 1'b0;
		evpage_d = '0;
		if (found_q) begin
			slot_d  = found_slot_q;
			orank_d = CNT_BITS'(found_rank_q);
		end else if (used_q < n_act) begin
			slot_d  = used_q[SLOT_BITS-1:0];
			orank_d = used_q;
		end else begin
			slot_d   = worst_slot_q;
			orank_d  = CNT_BITS'(worst_rank_q);
			evict_d  = 1'b1;
			evpage_d = worst_page_q;
		end
	end

	// recency cells: age everything younger than the touched frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < FRAMES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (SLOT_BITS'(i) == slot_d) begin
					valid_q[i] <= 1'b1;
					rank_q[i]  <= '0;
				end else if (valid_q[i] && CNT_BITS'(rank_q[i]) < orank_d) begin
					rank_q[i] <= rank_q[i] + SLOT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit) begin
				if (found_q) begin
					if (hit_cnt_q != COUNT_MAX) begin
						hit_cnt_q <= hit_cnt_q + COUNT_BITS'(1);
					end
				end else if (fault_cnt_q != COUNT_MAX) begin
					fault_cnt_q <= fault_cnt_q + COUNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q    <= found_q;
			slot_q   <= slot_d;
			evict_q  <= evict_d;
			evpage_q <= evpage_d;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = evict_q;
	assign evicted_page  = evpage_q;
	assign hit_total     = hit_cnt_q;
	assign fault_total   = fault_cnt_q;

	`ASSERT_CLK(a_done_after_commit, clk, arst_n, cmd.commit |=> done_q)
	`ASSERT_NEVER(a_done_single, clk, arst_n, done_q && $past(done_q))
	`ASSERT_CLK(a_slot_valid, clk, arst_n, (cmd.commit && !cfg_we) |=> valid_q[$past(slot_d)])
	`ASSERT_CLK(a_count_moves, clk, arst_n,
		cmd.commit |=> (hit_cnt_q != $past(hit_cnt_q)) || (fault_cnt_q != $past(fault_cnt_q)) ||
		(hit_cnt_q == COUNT_MAX) || (fault_cnt_q == COUNT_MAX))

endmodule

// File: src/lru_page_replacement.sv
// LRU page replacement: one page request in, one hit/fault result out.
// Steps: latch the request, scan the n frames in use (n = 1..FRAMES), drain, commit, done.
// A new request is taken only back in idle; the frame scan reads one memory word per cycle.
// done is high for one cycle; the receiver cannot stall, a new request may start meanwhile.
// Reset (arst_n low): frames empty, counts zero, frame count 8; a config write empties frames.
`timescale 1ns / 1ps
module lru_page_replacement #(
	parameter int FRAMES    = lru_pkg::DEF_FRAMES,
	parameter int PAGE_BITS = lru_pkg::DEF_PAGE_BITS,
	localparam int SLOT_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [PAGE_BITS-1:0]           page_number,
	input  logic                           cfg_we,
	input  logic [lru_pkg::CFG_BITS-1:0]   cfg_wdata,
	output logic                           done,
	output logic                           hit,
	output logic [SLOT_BITS-1:0]           frame_slot,
	output logic                           evicted_valid,
	output logic [PAGE_BITS-1:0]           evicted_page,
	output logic [lru_pkg::COUNT_BITS-1:0] hit_total,
	output logic [lru_pkg::COUNT_BITS-1:0] fault_total
);
	import lru_pkg::*;

	lru_cmd_t    cmd;
	lru_status_t status;

	lru_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lru_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.page_number   (page_number),
		.done          (done),
		.hit           (hit),
		.frame_slot    (frame_slot),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_total     (hit_total),
		.fault_total   (fault_total)
	);

endmodule

// File: verif/tb_top.sv
// Testbench for lru_page_replacement: directed and random page requests vs an LRU predictor.
`timescale 1ns / 1ps
module tb_top;
	import lru_pkg::*;

	localparam int NF = DEF_FRAMES;
	localparam int PB = DEF_PAGE_BITS;

	typedef struct packed {
		logic          hit;
		logic [2:0]    slot;
		logic          ev_valid;
		logic [PB-1:0] ev_page;
		logic [31:0]   hits;
		logic [31:0]   faults;
	} lru_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [PB-1:0]         page_number;
	logic                  cfg_we;
	logic [CFG_BITS-1:0]   cfg_wdata;
	logic                  done;
	logic                  hit;
	logic [2:0]            frame_slot;
	logic                  evicted_valid;
	logic [PB-1:0]         evicted_page;
	logic [COUNT_BITS-1:0] hit_total;
	logic [COUNT_BITS-1:0] fault_total;

	lru_page_replacement dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.page_number  (page_number),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.hit          (hit),
		.frame_slot   (frame_slot),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.hit_total    (hit_total),
		.fault_total  (fault_total)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// frame table as the block should hold it
	logic [PB-1:0]       ref_page [NF];
	logic                ref_valid [NF];
	logic [2:0]          ref_rank [NF];
	logic [31:0]         ref_hits;
	logic [31:0]         ref_faults;
	logic [CFG_BITS-1:0] ref_frames_cfg;

	lru_result_t expected_results[$];
	int          error_count;
	bit          no_idle;

	function automatic int active_frames();
		int n;
		n = int'(ref_frames_cfg);
		if (n < 1) n = 1;
		if (n > NF) n = NF;
		return n;
	endfunction

	function automatic void empty_frames();
		for (int i = 0; i < NF; i++) begin
			ref_page[i]  = '0;
			ref_valid[i] = 1'b0;
			ref_rank[i]  = '0;
		end
	endfunction

	// one reference: hit lookup, fill or LRU eviction, rank aging
	function automatic lru_result_t lru_lookup(input logic [PB-1:0] pg);
		int n;
		int used;
		int old_rank;
		int worst;
		int slot;
		bit found;
		lru_result_t r;
		n = active_frames();
		used = 0;
		slot = 0;
		found = 1'b0;
		r = '0;
		for (int i = 0; i < n; i++) begin
			if (ref_valid[i]) begin
				used++;
				if (!found && ref_page[i] == pg) begin
					found = 1'b1;
					slot = i;
				end
			end
		end
		if (found) begin
			old_rank = int'(ref_rank[slot]);
			if (ref_hits != COUNT_MAX) ref_hits++;
		end else begin
			if (used < n) begin
				slot = used;
				old_rank = used;
			end else begin
				worst = 0;
				for (int i = 0; i < n; i++) begin
					if (int'(ref_rank[i]) >= worst) begin
						worst = int'(ref_rank[i]);
						slot = i;
					end
				end
				old_rank = worst;
				r.ev_valid = 1'b1;
				r.ev_page = ref_page[slot];
			end
			if (ref_faults != COUNT_MAX) ref_faults++;
		end
		for (int i = 0; i < n; i++) begin
			if (i != slot && ref_valid[i] && int'(ref_rank[i]) < old_rank)
				ref_rank[i] = ref_rank[i] + 3'd1;
		end
		ref_page[slot]  = pg;
		ref_valid[slot] = 1'b1;
		ref_rank[slot]  = '0;
		r.hit    = found;
		r.slot   = slot[2:0];
		r.hits   = ref_hits;
		r.faults = ref_faults;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		lru_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				error_count++;
				$display("%0t: result with no request pending: expected none actual slot %h",
					$time, frame_slot);
			end else begin
				want = expected_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("frame_slot", 32'(want.slot), 32'(frame_slot));
				check_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid));
				check_field("evicted_page", 32'(want.ev_page), 32'(evicted_page));
				check_field("hit_total", want.hits, hit_total);
				check_field("fault_total", want.faults, fault_total);
			end
		end
	end

	function automatic int draw_gap();
		if (no_idle) return 0;
		return $urandom_range(0, 10);
	endfunction

	// start stays high across back-to-back requests; lowered only when a gap follows
	task automatic send_request(input logic [PB-1:0] pg);
		int gap;
		start <= 1'b1;
		page_number <= pg;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results = {expected_results, lru_lookup(pg)};
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (NF + 4) @(posedge clk);
	endtask

	task automatic write_frames(input logic [CFG_BITS-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		ref_frames_cfg = v;
		empty_frames();
	endtask

	task automatic test_reset_frames();
		no_idle = 1'b0;
		send_request(16'h0000);
		send_request(16'hFFFF);
		send_request(16'h0000);
		send_request(16'hFFFF);
	endtask

	// one frame, and a zero count that must act as one frame
	task automatic test_single_frame();
		write_frames(4'd1);
		send_request(16'hA5A5);
		send_request(16'hA5A5);
		send_request(16'h5A5A);
		write_frames(4'd0);
		send_request(16'h1234);
		send_request(16'h4321);
	endtask

	// count above the frame total clamps to 8; fill all, refresh one, evict the oldest
	task automatic test_full_eviction();
		no_idle = 1'b1;
		write_frames(4'd15);
		for (int p = 1; p <= NF; p++) send_request(p[PB-1:0]);
		send_request(16'd1);
		send_request(16'd9);
		no_idle = 1'b0;
	endtask

	task automatic run_mix(input int count, input int ws_size);
		logic [PB-1:0] ws [16];
		for (int i = 0; i < 16; i++) ws[i] = PB'($urandom_range(0, 16'hFFFF));
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 85)
				send_request(ws[$urandom_range(0, ws_size - 1)]);
			else if ($urandom_range(0, 9) == 0)
				send_request($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
			else
				send_request(PB'($urandom_range(0, 16'hFFFF)));
			// let the working set drift now and then
			if ($urandom_range(0, 39) == 0) ws[$urandom_range(0, ws_size - 1)] = PB'($urandom);
		end
	endtask

	// sender stops until every pending result is back, then resumes
	task automatic test_pause_midstream();
		write_frames(4'd4);
		run_mix(20, 6);
		wait_idle();
		run_mix(20, 6);
	endtask

	task automatic test_random_phases();
		logic [CFG_BITS-1:0] cfgs [12] = '{4'd8, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
			4'd6, 4'd7, 4'd0, 4'd9, 4'd15, 4'd8};
		int n;
		for (int ph = 0; ph < 12; ph++) begin
			write_frames(cfgs[ph]);
			n = active_frames();
			no_idle = ($urandom_range(0, 3) == 0);
			run_mix(90, $urandom_range(1, n + 3));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		page_number = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		error_count = 0;
		no_idle = 1'b0;
		empty_frames();
		ref_hits = '0;
		ref_faults = '0;
		ref_frames_cfg = CFG_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_frames();
		test_single_frame();
		test_full_eviction();
		test_pause_midstream();
		test_random_phases();
		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/lru_pkg.sv
src/lru_ctrl.sv
src/lru_dp.sv
src/lru_page_replacement.sv
verif/tb_top.sv
